// ===== design/cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared constants for the cartridge bank mapper: cartridge type codes,
// region codes, bus windows and fixed image offsets.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // cartridge type codes
  localparam logic [2:0] CART_NORMAL     = 3'd0;
  localparam logic [2:0] CART_SUPER      = 3'd1;
  localparam logic [2:0] CART_LARGE      = 3'd2;
  localparam logic [2:0] CART_RAM        = 3'd3;
  localparam logic [2:0] CART_EXTRA_ROM  = 3'd4;
  localparam logic [2:0] CART_ABSOLUTE   = 3'd5;
  localparam logic [2:0] CART_ACTIVISION = 3'd6;

  // region codes
  localparam logic [1:0] REGION_NONE = 2'd0;
  localparam logic [1:0] REGION_ROM  = 2'd1;
  localparam logic [1:0] REGION_RAM  = 2'd2;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic REG_CART_TYPE  = 1'b0;
  localparam logic REG_IMAGE_SIZE = 1'b1;

  // internal offset width, wide enough for every mapped offset
  localparam int OFF_CALC_W = 20;

  // bus window bounds
  localparam logic [15:0] ADDR_4000 = 16'h4000;
  localparam logic [15:0] ADDR_6000 = 16'h6000;
  localparam logic [15:0] ADDR_8000 = 16'h8000;
  localparam logic [15:0] ADDR_A000 = 16'hA000;
  localparam logic [15:0] ADDR_C000 = 16'hC000;
  localparam logic [15:0] ADDR_E000 = 16'hE000;
  localparam logic [15:0] ADDR_FF80 = 16'hFF80;

  // highest bank data accepted by the supercart types
  localparam logic [7:0] SUPER_DATA_MAX = 8'd8;

  // activision fixed window offsets into the image
  localparam logic [OFF_CALC_W-1:0] ACT_OFF_4000 = 20'd106496;
  localparam logic [OFF_CALC_W-1:0] ACT_OFF_6000 = 20'd98304;
  localparam logic [OFF_CALC_W-1:0] ACT_OFF_8000 = 20'd122880;
  localparam logic [OFF_CALC_W-1:0] ACT_OFF_E000 = 20'd114688;
  localparam logic [18:0]           ACT_MIN_SIZE = 19'd122880;

  // bank numbers of the fixed windows
  localparam logic [3:0] BANK_FIXED_HI       = 4'd7;
  localparam logic [3:0] BANK_FIXED_HI_LARGE = 4'd8;
  localparam logic [3:0] BANK_EXTRA          = 4'd6;

endpackage

// ===== design/cartridge_bank_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Maps CPU bus accesses onto a 7800 cartridge image for seven cartridge types,
// tracking the bank register written by bank-switch accesses.
// ----------------------------------------------------------------------------
// One access request enters on the slave stream each cycle while the master
// stream is not stalled, and its mapping (region, image offset, bank after the
// access) leaves on the master stream via the input and result registers.
// Throughput is one request per clock on that condition; the only loop is the
// bank register and loaded flag, updated in the same cycle the request is
// mapped, so back-to-back bank writes take effect on the very next request.
// The cartridge type and image size are set through the APB port and must only
// be changed while no request is in flight; bank state is not touched by them.
module cartridge_bank_mapper
  import cbm_pkg::*;
#(
  parameter int OFFSET_BITS = 18
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operation[0], address[16:1], write_data[24:17]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // region[1:0], cart_offset[OFFSET_BITS+1:2], bank_now[OFFSET_BITS+5:OFFSET_BITS+2]
  output logic [((OFFSET_BITS+6+7)/8)*8-1:0] m_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MDW = ((OFFSET_BITS + 6 + 7) / 8) * 8;
  localparam int PAD = MDW - (OFFSET_BITS + 6);

  // configuration registers
  logic [2:0]  cart_type;
  logic [18:0] image_size;

  // input register
  logic        in_valid;
  logic        in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_data;

  // bank state
  logic [3:0]  bank_reg, bank_reg_next;
  logic        window_loaded, window_loaded_next;

  // result register
  logic                   out_valid;
  logic [1:0]             out_region;
  logic [OFFSET_BITS-1:0] out_offset;
  logic [3:0]             out_bank;

  // mapping results
  logic                  advance;
  logic                  bank_sel;
  logic [3:0]            bank_cand;
  logic [1:0]            map_region;
  logic [OFF_CALC_W-1:0] map_offset;
  logic [16:0]           norm_size;
  logic [16:0]           norm_base;
  logic [16:0]           norm_diff;
  logic [3:0]            hi_bank;
  logic                  hi_ok;
  logic [15:0]           act_diff;

  // apb slave
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type  <= CART_NORMAL;
      image_size <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CART_TYPE) begin
        cart_type <= pwdata[2:0];
      end else begin
        image_size <= pwdata[18:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CART_TYPE) begin
      prdata = {29'd0, cart_type};
    end else begin
      prdata = {13'd0, image_size};
    end
  end

  // handshake: input register moves on when the result register frees up
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tdata[0];
      in_addr <= s_tdata[16:1];
      in_data <= s_tdata[24:17];
    end
  end

  // bank write decode
  always_comb begin
    bank_sel  = 1'b0;
    bank_cand = '0;
    if (in_op == OP_WRITE) begin
      case (cart_type)
        CART_SUPER, CART_RAM, CART_EXTRA_ROM: begin
          bank_sel  = in_addr >= ADDR_8000 && in_addr < ADDR_C000
                      && in_data <= SUPER_DATA_MAX;
          bank_cand = in_data[3:0];
        end
        CART_LARGE: begin
          bank_sel  = in_addr >= ADDR_8000 && in_addr < ADDR_C000
                      && in_data <= SUPER_DATA_MAX;
          bank_cand = in_data[3:0] + 4'd1;
        end
        CART_ABSOLUTE: begin
          bank_sel  = in_addr == ADDR_8000 && (in_data == 8'd1 || in_data == 8'd2);
          bank_cand = in_data[3:0] - 4'd1;
        end
        CART_ACTIVISION: begin
          bank_sel  = in_addr >= ADDR_FF80;
          bank_cand = {1'b0, in_addr[2:0]};
        end
        default: begin
          bank_sel  = 1'b0;
          bank_cand = '0;
        end
      endcase
    end
  end

  // bank taken only when it starts inside the image
  always_comb begin
    bank_reg_next      = bank_reg;
    window_loaded_next = window_loaded;
    if (bank_sel && {1'b0, bank_cand, 14'd0} < image_size) begin
      bank_reg_next      = bank_cand;
      window_loaded_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_reg      <= '0;
      window_loaded <= 1'b0;
    end else if (in_valid && advance) begin
      bank_reg      <= bank_reg_next;
      window_loaded <= window_loaded_next;
    end
  end

  // address mapping with the bank state after this access
  always_comb begin
    norm_size  = image_size > 19'h10000 ? 17'h10000 : image_size[16:0];
    norm_base  = 17'h10000 - norm_size;
    norm_diff  = {1'b0, in_addr} - norm_base;
    hi_bank    = (cart_type == CART_LARGE) ? BANK_FIXED_HI_LARGE : BANK_FIXED_HI;
    hi_ok      = {1'b0, hi_bank, 14'd0} < image_size;
    act_diff   = in_addr - ADDR_A000;
    map_region = REGION_NONE;
    map_offset = '0;
    case (cart_type)
      CART_NORMAL: begin
        if (norm_size != 17'd0 && {1'b0, in_addr} >= norm_base) begin
          map_region = REGION_ROM;
          map_offset = {3'd0, norm_diff};
        end
      end
      CART_SUPER, CART_LARGE, CART_RAM, CART_EXTRA_ROM: begin
        if (window_loaded_next && in_addr >= ADDR_8000 && in_addr < ADDR_C000) begin
          map_region = REGION_ROM;
          map_offset = {2'd0, bank_reg_next, in_addr[13:0]};
        end else if (hi_ok) begin
          if (in_addr >= ADDR_C000) begin
            map_region = REGION_ROM;
            map_offset = {2'd0, hi_bank, in_addr[13:0]};
          end else if (in_addr >= ADDR_4000 && in_addr < ADDR_8000) begin
            if (cart_type == CART_LARGE) begin
              map_region = REGION_ROM;
              map_offset = {6'd0, in_addr[13:0]};
            end else if (cart_type == CART_RAM) begin
              map_region = REGION_RAM;
              map_offset = {6'd0, in_addr[13:0]};
            end else if (cart_type == CART_EXTRA_ROM) begin
              map_region = REGION_ROM;
              map_offset = {2'd0, BANK_EXTRA, in_addr[13:0]};
            end
          end
        end
      end
      CART_ABSOLUTE: begin
        if (in_addr >= ADDR_4000 && in_addr < ADDR_8000) begin
          map_region = REGION_ROM;
          map_offset = {2'd0, (window_loaded_next ? bank_reg_next : 4'd0), in_addr[13:0]};
        end else if (in_addr >= ADDR_8000) begin
          map_region = REGION_ROM;
          map_offset = {4'd0, in_addr};
        end
      end
      CART_ACTIVISION: begin
        if (window_loaded_next && in_addr >= ADDR_A000 && in_addr < ADDR_E000) begin
          map_region = REGION_ROM;
          map_offset = {2'd0, bank_reg_next, act_diff[13:0]};
        end else if (image_size > ACT_MIN_SIZE) begin
          map_region = REGION_ROM;
          if (in_addr >= ADDR_A000 && in_addr < ADDR_E000) begin
            map_offset = {6'd0, act_diff[13:0]};
          end else if (in_addr >= ADDR_4000 && in_addr < ADDR_6000) begin
            map_offset = ACT_OFF_4000 + {7'd0, in_addr[12:0]};
          end else if (in_addr >= ADDR_6000 && in_addr < ADDR_8000) begin
            map_offset = ACT_OFF_6000 + {7'd0, in_addr[12:0]};
          end else if (in_addr >= ADDR_8000 && in_addr < ADDR_A000) begin
            map_offset = ACT_OFF_8000 + {7'd0, in_addr[12:0]};
          end else if (in_addr >= ADDR_E000) begin
            map_offset = ACT_OFF_E000 + {7'd0, in_addr[12:0]};
          end else begin
            map_region = REGION_NONE;
          end
        end
      end
      default: begin
        map_region = REGION_NONE;
        map_offset = '0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_region <= map_region;
      out_offset <= map_offset[OFFSET_BITS-1:0];
      out_bank   <= bank_reg_next;
    end
  end

  assign m_tvalid = out_valid;

  generate
    if (PAD > 0) begin : g_pad
      assign m_tdata = {{PAD{1'b0}}, out_bank, out_offset, out_region};
    end else begin : g_nopad
      assign m_tdata = {out_bank, out_offset, out_region};
    end
  endgenerate

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cartridge bank mapper. Bus access requests go
// in on the slave stream in random bursts while the result stream stalls on
// its own pattern. A scoreboard class tracks cartridge type, image size, bank
// register and loaded flag, predicts region, image offset and bank for every
// accepted request, and compares each mapping against the oldest prediction.
// A directed opener hits each cartridge type, window edges, rejected bank
// writes and the saturating normal image. Random phases follow, each under a
// fresh register setting applied over APB while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import cbm_pkg::*;

  localparam int          OFFSET_BITS    = 18;
  localparam int          RES_W          = ((OFFSET_BITS + 6 + 7) / 8) * 8;
  localparam int          BANK_BYTES     = 16384;
  localparam logic [2:0]  CART_UNDEFINED = 3'd7;
  localparam int          PHASES         = 14;
  localparam int          PHASE_ACCESSES = 130;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          MAX_PRINTS     = 40;

  typedef struct packed {
    logic [1:0]             region;
    logic [OFFSET_BITS-1:0] offset;
    logic [3:0]             bank;
  } mapping_t;

  // predicts the mapping of each request and holds it until it comes out
  class mapping_board;
    logic [2:0]  ctype;
    logic [18:0] isize;
    logic [3:0]  bank;
    bit          loaded;
    mapping_t    expected_maps[$];
    int          errors;
    int          checked;
    int          switches;

    function new();
      ctype    = CART_NORMAL;
      isize    = '0;
      bank     = '0;
      loaded   = 1'b0;
      errors   = 0;
      checked  = 0;
      switches = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function int pending();
      return expected_maps.size();
    endfunction

    // a selected bank only sticks if it lies inside the image
    function void take_bank(int unsigned sel);
      if (sel * BANK_BYTES < isize) begin
        bank   = sel[3:0];
        loaded = 1'b1;
        switches++;
      end
    endfunction

    function void bank_switch(int unsigned a, int unsigned d);
      case (ctype)
        CART_SUPER, CART_RAM, CART_EXTRA_ROM: begin
          if (a >= ADDR_8000 && a < ADDR_C000 && d <= SUPER_DATA_MAX) take_bank(d);
        end
        CART_LARGE: begin
          if (a >= ADDR_8000 && a < ADDR_C000 && d <= SUPER_DATA_MAX) take_bank(d + 1);
        end
        CART_ABSOLUTE: begin
          if (a == ADDR_8000 && (d == 1 || d == 2)) take_bank(d - 1);
        end
        CART_ACTIVISION: begin
          if (a >= ADDR_FF80) take_bank(a & 7);
        end
        default: ;
      endcase
    endfunction

    function void map_window(int unsigned a, output logic [1:0] rg, output int unsigned off);
      int unsigned size;
      int unsigned hi;
      rg  = REGION_NONE;
      off = 0;
      case (ctype)
        CART_NORMAL: begin
          // large images saturate to the full 64 KiB
          size = (isize > 65536) ? 65536 : isize;
          if (size > 0 && a >= 65536 - size) begin
            rg  = REGION_ROM;
            off = a - (65536 - size);
          end
        end
        CART_SUPER, CART_LARGE, CART_RAM, CART_EXTRA_ROM: begin
          hi = (ctype == CART_LARGE) ? BANK_FIXED_HI_LARGE : BANK_FIXED_HI;
          if (loaded && a >= ADDR_8000 && a < ADDR_C000) begin
            rg  = REGION_ROM;
            off = bank * BANK_BYTES + (a - ADDR_8000);
          end else if (hi * BANK_BYTES < isize) begin
            if (a >= ADDR_C000) begin
              rg  = REGION_ROM;
              off = hi * BANK_BYTES + (a - ADDR_C000);
            end else if (a >= ADDR_4000 && a < ADDR_8000) begin
              case (ctype)
                CART_LARGE: begin
                  rg  = REGION_ROM;
                  off = a - ADDR_4000;
                end
                CART_RAM: begin
                  rg  = REGION_RAM;
                  off = a - ADDR_4000;
                end
                CART_EXTRA_ROM: begin
                  rg  = REGION_ROM;
                  off = BANK_EXTRA * BANK_BYTES + (a - ADDR_4000);
                end
                default: ;
              endcase
            end
          end
        end
        CART_ABSOLUTE: begin
          // no size check here, offsets may run past the image
          if (a >= ADDR_4000 && a < ADDR_8000) begin
            rg  = REGION_ROM;
            off = (loaded ? bank * BANK_BYTES : 0) + (a - ADDR_4000);
          end else if (a >= ADDR_8000) begin
            rg  = REGION_ROM;
            off = a;
          end
        end
        CART_ACTIVISION: begin
          if (loaded && a >= ADDR_A000 && a < ADDR_E000) begin
            rg  = REGION_ROM;
            off = bank * BANK_BYTES + (a - ADDR_A000);
          end else if (isize > ACT_MIN_SIZE) begin
            rg = REGION_ROM;
            if (a >= ADDR_A000 && a < ADDR_E000) off = a - ADDR_A000;
            else if (a >= ADDR_4000 && a < ADDR_6000) off = ACT_OFF_4000 + (a - ADDR_4000);
            else if (a >= ADDR_6000 && a < ADDR_8000) off = ACT_OFF_6000 + (a - ADDR_6000);
            else if (a >= ADDR_8000 && a < ADDR_A000) off = ACT_OFF_8000 + (a - ADDR_8000);
            else if (a >= ADDR_E000) off = ACT_OFF_E000 + (a - ADDR_E000);
            else rg = REGION_NONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_access(logic op, logic [15:0] addr, logic [7:0] wdata);
      mapping_t    m;
      logic [1:0]  rg;
      int unsigned off;
      if (op == OP_WRITE) bank_switch(addr, wdata);
      map_window(addr, rg, off);
      m.region = rg;
      m.offset = off[OFFSET_BITS-1:0];
      m.bank   = bank;
      expected_maps.push_back(m);
    endfunction

    task check_mapping(logic [RES_W-1:0] data);
      mapping_t got;
      mapping_t exp_m;
      got.region = data[1:0];
      got.offset = data[OFFSET_BITS+1:2];
      got.bank   = data[OFFSET_BITS+5:OFFSET_BITS+2];
      if (expected_maps.size() == 0) begin
        report($sformatf("unexpected result %h", data));
      end else begin
        exp_m = expected_maps.pop_front();
        checked++;
        if (got.region !== exp_m.region)
          report($sformatf("region %0d, predicted %0d", got.region, exp_m.region));
        if (got.offset !== exp_m.offset)
          report($sformatf("offset %0d, predicted %0d", got.offset, exp_m.offset));
        if (got.bank !== exp_m.bank)
          report($sformatf("bank %0d, predicted %0d", got.bank, exp_m.bank));
      end
    endtask
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;   // operation[0], address[16:1], write_data[24:17]
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;        // region[1:0], cart_offset[19:2], bank_now[23:20]
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  mapping_board board = new();
  int           cycle_count = 0;
  int           stall_mode = 0;
  int           mode_left = 0;
  int           settings_used = 0;

  cartridge_bank_mapper #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side stall pattern, switching between four modes at random
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((cycle_count % 7) < 4);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_mapping(m_tdata);
  end

  task send_access(logic op, logic [15:0] addr, logic [7:0] wdata);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, wdata, addr, op};
    do @(posedge clk); while (!s_tready);
    board.note_access(op, addr, wdata);
  endtask

  // hold the request side until every predicted mapping has come out
  task drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task cfg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task cfg_read_check(logic [2:0] addr, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      board.report($sformatf("register at %0d reads %0h, wrote %0h", addr, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // new register setting, only applied with nothing in flight
  task set_cartridge(logic [2:0] ctype, logic [18:0] isize);
    drain();
    cfg_write({REG_CART_TYPE, 2'b00}, {29'b0, ctype});
    cfg_read_check({REG_CART_TYPE, 2'b00}, {29'b0, ctype});
    cfg_write({REG_IMAGE_SIZE, 2'b00}, {13'b0, isize});
    cfg_read_check({REG_IMAGE_SIZE, 2'b00}, {13'b0, isize});
    board.ctype = ctype;
    board.isize = isize;
    settings_used++;
  endtask

  task directed(logic [2:0] ctype, logic [18:0] isize, logic op, logic [15:0] addr,
                logic [7:0] wdata);
    if (ctype != board.ctype || isize != board.isize || settings_used == 0)
      set_cartridge(ctype, isize);
    send_access(op, addr, wdata);
  endtask

  function logic [18:0] pick_size();
    logic [18:0] sizes [17];
    sizes = '{19'd0, 19'd1, 19'd16383, 19'd16384, 19'd65535, 19'd65536, 19'd65537,
              19'd114688, 19'd114689, 19'd122880, 19'd122881, 19'd131072, 19'd131073,
              19'd147456, 19'd147457, 19'd262143, 19'd262144};
    if ($urandom_range(0, 3) == 0) return 19'($urandom_range(0, 262144));
    return sizes[$urandom_range(0, 16)];
  endfunction

  // mostly bank switch requests and window edges, the rest plain noise
  task random_access();
    logic [15:0] edges [10];
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        op;
    int          r;
    edges = '{ADDR_4000, ADDR_6000, ADDR_8000, ADDR_A000, ADDR_C000, ADDR_E000,
               ADDR_FF80, 16'h0000, 16'hBF00, 16'hDF00};
    r     = $urandom_range(0, 99);
    op    = 1'($urandom_range(0, 1));
    addr  = 16'($urandom_range(0, 65535));
    wdata = 8'($urandom_range(0, 255));
    if (r < 35) begin
      op = ($urandom_range(0, 4) != 0) ? OP_WRITE : OP_READ;
      case (board.ctype)
        CART_ABSOLUTE: begin
          addr  = ADDR_8000;
          wdata = 8'($urandom_range(0, 3));
        end
        CART_ACTIVISION: addr = 16'($urandom_range(ADDR_FF80, 16'hFFFF));
        default: begin
          addr  = 16'($urandom_range(ADDR_8000, 16'hBFFF));
          wdata = 8'($urandom_range(0, 10));
        end
      endcase
    end else if (r < 70) begin
      addr = edges[$urandom_range(0, 9)] + 16'($urandom_range(0, 2)) - 16'd1;
    end
    send_access(op, addr, wdata);
  endtask

  initial begin
    int burst;
    int gap;
    int sent;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opener
    directed(CART_NORMAL, 19'd0, OP_READ, 16'hFFFF, 8'h00);
    directed(CART_NORMAL, 19'd65537, OP_READ, 16'h0000, 8'hFF);
    directed(CART_NORMAL, 19'd65537, OP_WRITE, 16'hFFFF, 8'hAA);
    directed(CART_NORMAL, 19'd16384, OP_READ, 16'hBFFF, 8'h00);
    directed(CART_NORMAL, 19'd16384, OP_READ, ADDR_C000, 8'h00);
    directed(CART_SUPER, 19'd131072, OP_READ, ADDR_8000, 8'h00);
    directed(CART_SUPER, 19'd131072, OP_WRITE, ADDR_8000, 8'd8);
    directed(CART_SUPER, 19'd131072, OP_WRITE, 16'hBFFF, 8'd7);
    directed(CART_SUPER, 19'd131072, OP_WRITE, ADDR_8000, 8'd9);
    directed(CART_SUPER, 19'd131072, OP_READ, ADDR_4000, 8'h00);
    directed(CART_SUPER, 19'd131072, OP_READ, 16'hFFFF, 8'h00);
    // type change keeps the loaded bank
    directed(CART_ABSOLUTE, 19'd16384, OP_READ, ADDR_4000, 8'h00);
    directed(CART_ABSOLUTE, 19'd16384, OP_WRITE, ADDR_8000, 8'd2);
    directed(CART_ABSOLUTE, 19'd16384, OP_WRITE, ADDR_8000, 8'd1);
    directed(CART_ABSOLUTE, 19'd16384, OP_READ, 16'hFFFF, 8'h00);
    directed(CART_ACTIVISION, 19'd122881, OP_WRITE, 16'hFF85, 8'h00);
    directed(CART_ACTIVISION, 19'd122881, OP_READ, ADDR_A000, 8'h00);
    directed(CART_ACTIVISION, 19'd122881, OP_READ, ADDR_4000, 8'h00);
    directed(CART_ACTIVISION, 19'd122881, OP_READ, ADDR_6000, 8'h00);
    directed(CART_ACTIVISION, 19'd122881, OP_READ, ADDR_8000, 8'h00);
    directed(CART_ACTIVISION, 19'd122881, OP_READ, ADDR_E000, 8'h00);
    directed(CART_LARGE, 19'd147457, OP_WRITE, ADDR_8000, 8'd8);
    directed(CART_LARGE, 19'd147457, OP_READ, ADDR_C000, 8'h00);
    directed(CART_RAM, 19'd262144, OP_READ, 16'h7FFF, 8'h00);
    directed(CART_EXTRA_ROM, 19'd262144, OP_READ, ADDR_4000, 8'h00);
    directed(CART_UNDEFINED, 19'd262144, OP_WRITE, ADDR_FF80, 8'h01);
    directed(CART_UNDEFINED, 19'd262144, OP_READ, ADDR_8000, 8'h00);

    // random phases, each type at least once, then random settings
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) set_cartridge(3'(p), pick_size());
      else set_cartridge(($urandom_range(0, 9) == 0) ? CART_UNDEFINED
                                                     : 3'($urandom_range(0, 6)), pick_size());
      sent = 0;
      while (sent < PHASE_ACCESSES) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && sent < PHASE_ACCESSES; k++) begin
          random_access();
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // let the pipeline empty out
    drain();
    repeat (8) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d predicted mappings never came out", board.pending()));
    $display("checked %0d mappings over %0d register settings, %0d bank switches taken",
             board.checked, settings_used, board.switches);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
